// File: design/tvfp_pkg.sv
// Shared types and constants for the tag=value field parser.
// No dependencies; the parser top level refers to it by scoped names.
package tvfp_pkg;

    localparam int unsigned TAG_W  = 20;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned PROD_W = TAG_W + 4;

    localparam logic [BYTE_W-1:0] SEP_BYTE   = 8'h7C;
    localparam logic [BYTE_W-1:0] EQ_BYTE    = 8'h3D;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;
    localparam logic [PROD_W-1:0] TAG_MAX    = 24'h0FFFFF;

    // result kind carried on the master tuser
    typedef enum logic [1:0] {
        KIND_VALUE     = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_BAD_TAG   = 2'd2
    } kind_t;

    // one result transaction
    typedef struct packed {
        logic [TAG_W-1:0]  field_tag;
        logic [BYTE_W-1:0] value_byte;
        kind_t             kind;
        logic              end_of_message;
    } result_t;

endpackage

// File: design/tag_value_field_parser.sv
// Tag=value field parser top level: parse state, result register and skid stage.
// Depends on tvfp_pkg for constants, the result kind and the result struct.
//
//  channel  | dir | tdata (low bit up)                      | tuser | tlast
//  s_axis   | in  | data_byte[7:0]                          | -     | message_end
//  m_axis   | out | field_tag[19:0], value_byte[27:20], 0s  | kind  | end_of_message
//
// One byte per cycle while tready is high: the parse state (phase, tag accumulator,
// flags) is updated by one shift-add and compare at acceptance, and the result lands in
// the output register in the same edge, or in the skid register behind it while a result
// waits there, which keeps the input open; tready drops only when both hold a result.
// Reset clears the parse state and both valid flags.
module tag_value_field_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // field_tag[19:0], value_byte[27:20], zero pad
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);

    // parse state
    logic                         in_value_reg, in_value_next;
    logic [tvfp_pkg::TAG_W-1:0]   tag_accum_reg, tag_accum_next;
    logic                         digit_seen_reg, digit_seen_next;
    logic                         digits_stopped_reg, digits_stopped_next;
    logic                         token_dropped_reg, token_dropped_next;

    // output and skid stages
    logic                         out_valid_reg;
    tvfp_pkg::result_t            out_data_reg;
    logic                         skid_valid_reg;
    tvfp_pkg::result_t            skid_data_reg;

    logic                         accept;
    logic                         pop;
    logic                         res_valid;
    tvfp_pkg::result_t            res;
    logic                         clear_tok;
    logic [tvfp_pkg::PROD_W-1:0]  tag_prod;
    logic                         is_sep;
    logic                         is_eq;
    logic                         is_digit;
    logic                         eom;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;

    assign eom      = s_axis_tlast;
    assign is_sep   = (s_axis_tdata == tvfp_pkg::SEP_BYTE);
    assign is_eq    = (s_axis_tdata == tvfp_pkg::EQ_BYTE);
    assign is_digit = s_axis_tdata inside {[tvfp_pkg::DIGIT_ZERO:tvfp_pkg::DIGIT_NINE]};

    // tag * 10 + digit as two shifts and adds
    assign tag_prod = ({4'b0000, tag_accum_reg} << 3) + ({4'b0000, tag_accum_reg} << 1)
                    + {{(tvfp_pkg::PROD_W-4){1'b0}}, s_axis_tdata[3:0]};

    // parse step for the byte on the input
    always_comb
    begin
        in_value_next       = in_value_reg;
        tag_accum_next      = tag_accum_reg;
        digit_seen_next     = digit_seen_reg;
        digits_stopped_next = digits_stopped_reg;
        token_dropped_next  = token_dropped_reg;
        clear_tok           = 1'b0;
        res_valid           = 1'b0;
        res.field_tag       = tag_accum_reg;
        res.value_byte      = '0;
        res.kind            = tvfp_pkg::KIND_VALUE;
        res.end_of_message  = eom;

        if (token_dropped_reg)
        begin
            clear_tok = is_sep || eom;
        end
        else if (in_value_reg)
        begin
            res_valid = 1'b1;
            if (is_sep)
            begin
                res.kind  = tvfp_pkg::KIND_FIELD_END;
                clear_tok = 1'b1;
            end
            else
            begin
                res.value_byte = s_axis_tdata;
                clear_tok      = eom;
            end
        end
        else if (is_sep)
        begin
            clear_tok = 1'b1;
        end
        else if (is_eq)
        begin
            if (digit_seen_reg)
            begin
                in_value_next = 1'b1;
                if (eom)
                begin
                    res_valid = 1'b1;
                    res.kind  = tvfp_pkg::KIND_FIELD_END;
                end
            end
            else
            begin
                res_valid          = 1'b1;
                res.field_tag      = '0;
                res.kind           = tvfp_pkg::KIND_BAD_TAG;
                token_dropped_next = 1'b1;
            end
            clear_tok = eom;
        end
        else
        begin
            // tag digits until the first non-digit or overflow
            if (!digits_stopped_reg)
            begin
                if (is_digit)
                begin
                    if (tag_prod > tvfp_pkg::TAG_MAX)
                    begin
                        digit_seen_next     = 1'b0;
                        digits_stopped_next = 1'b1;
                    end
                    else
                    begin
                        tag_accum_next  = tag_prod[tvfp_pkg::TAG_W-1:0];
                        digit_seen_next = 1'b1;
                    end
                end
                else
                begin
                    digits_stopped_next = 1'b1;
                end
            end
            clear_tok = eom;
        end

        if (clear_tok)
        begin
            in_value_next       = 1'b0;
            tag_accum_next      = '0;
            digit_seen_next     = 1'b0;
            digits_stopped_next = 1'b0;
            token_dropped_next  = 1'b0;
        end
    end

    // parse state registers, updated per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_value_reg       <= 1'b0;
            tag_accum_reg      <= '0;
            digit_seen_reg     <= 1'b0;
            digits_stopped_reg <= 1'b0;
            token_dropped_reg  <= 1'b0;
        end
        else if (accept)
        begin
            in_value_reg       <= in_value_next;
            tag_accum_reg      <= tag_accum_next;
            digit_seen_reg     <= digit_seen_next;
            digits_stopped_reg <= digits_stopped_next;
            token_dropped_reg  <= token_dropped_next;
        end
    end

    // output register with skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept && res_valid;
                end
            end
            else if (accept && res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload of both stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
        else if (accept && res_valid)
        begin
            skid_data_reg <= res;
        end
    end

    // master side
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_data_reg.value_byte, out_data_reg.field_tag};
    assign m_axis_tuser  = out_data_reg.kind;
    assign m_axis_tlast  = out_data_reg.end_of_message;

endmodule

// File: bench/testbench.sv
// Self-checking bench for the tag=value field parser: random and directed byte streams,
// predicted results checked in order against the master stream.
// Depends on tvfp_pkg and tag_value_field_parser.
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    // one input byte with its end-of-message mark
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // data_byte[7:0]
    logic        s_axis_tlast = 1'b0;   // message_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // field_tag[19:0], value_byte[27:20], zero pad
    logic [1:0]  m_axis_tuser;          // kind[1:0]
    logic        m_axis_tlast;          // end_of_message

    stream_byte_t        pending_q[$];
    logic [7:0]          msg_q[$];
    tvfp_pkg::result_t   expected_q[$];
    stream_byte_t        drive_item;
    tvfp_pkg::result_t   want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int cycle_count = 0;

    // parser state mirror
    logic                       in_value = 1'b0;
    logic [tvfp_pkg::TAG_W-1:0] tag_acc = '0;
    logic                       digit_seen = 1'b0;
    logic                       digits_stopped = 1'b0;
    logic                       token_dropped = 1'b0;

    tag_value_field_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // back to tag phase with an empty accumulator
    task automatic clear_token();
        in_value       = 1'b0;
        tag_acc        = '0;
        digit_seen     = 1'b0;
        digits_stopped = 1'b0;
        token_dropped  = 1'b0;
    endtask

    task automatic expect_result(input logic [tvfp_pkg::TAG_W-1:0] tag, input logic [7:0] vb,
                                 input tvfp_pkg::kind_t kind, input logic eom);
        tvfp_pkg::result_t r;
        r.field_tag      = tag;
        r.value_byte     = vb;
        r.kind           = kind;
        r.end_of_message = eom;
        expected_q.push_back(r);
    endtask

    // advance the parser mirror by one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [tvfp_pkg::PROD_W-1:0] next_tag;
        if (token_dropped)
        begin
            if (b == tvfp_pkg::SEP_BYTE || last)
                clear_token();
        end
        else if (in_value)
        begin
            if (b == tvfp_pkg::SEP_BYTE)
            begin
                expect_result(tag_acc, 8'd0, tvfp_pkg::KIND_FIELD_END, last);
                clear_token();
            end
            else
            begin
                expect_result(tag_acc, b, tvfp_pkg::KIND_VALUE, last);
                if (last)
                    clear_token();
            end
        end
        else if (b == tvfp_pkg::SEP_BYTE)
        begin
            clear_token();
        end
        else if (b == tvfp_pkg::EQ_BYTE)
        begin
            if (digit_seen)
            begin
                in_value = 1'b1;
                if (last)
                    expect_result(tag_acc, 8'd0, tvfp_pkg::KIND_FIELD_END, 1'b1);
            end
            else
            begin
                expect_result('0, 8'd0, tvfp_pkg::KIND_BAD_TAG, last);
                token_dropped = 1'b1;
            end
            if (last)
                clear_token();
        end
        else
        begin
            // tag digits until the first non-digit, overflow kills the tag
            if (!digits_stopped)
            begin
                if (b >= tvfp_pkg::DIGIT_ZERO && b <= tvfp_pkg::DIGIT_NINE)
                begin
                    next_tag = {4'd0, tag_acc} * 24'd10
                             + {16'd0, b - tvfp_pkg::DIGIT_ZERO};
                    if (next_tag > tvfp_pkg::TAG_MAX)
                    begin
                        digit_seen     = 1'b0;
                        digits_stopped = 1'b1;
                    end
                    else
                    begin
                        tag_acc    = next_tag[tvfp_pkg::TAG_W-1:0];
                        digit_seen = 1'b1;
                    end
                end
                else
                begin
                    digits_stopped = 1'b1;
                end
            end
            if (last)
                clear_token();
        end
    endtask

    // sender: presents queued bytes, mirrors every accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'd0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drive_item = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= drive_item.data;
                    s_axis_tlast  <= drive_item.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: tdata %h kind %0d last %0d",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tdata[19:0] !== want.field_tag)
                begin
                    $error("field_tag: expected %0d, got %0d", want.field_tag,
                           m_axis_tdata[19:0]);
                    err_count++;
                end
                if (m_axis_tdata[27:20] !== want.value_byte)
                begin
                    $error("value_byte: expected %h, got %h", want.value_byte,
                           m_axis_tdata[27:20]);
                    err_count++;
                end
                if (m_axis_tdata[31:28] !== 4'd0)
                begin
                    $error("tdata pad: expected 0, got %h", m_axis_tdata[31:28]);
                    err_count++;
                end
                if (m_axis_tuser !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tlast !== want.end_of_message)
                begin
                    $error("end_of_message: expected %0d, got %0d", want.end_of_message,
                           m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_q.push_back(s[i]);
    endtask

    // move the assembled message to the send queue, last byte marked
    task automatic emit_message();
        stream_byte_t item;
        for (int i = 0; i < msg_q.size(); i++)
        begin
            item.data = msg_q[i];
            item.last = (i == msg_q.size() - 1);
            pending_q.push_back(item);
        end
        msg_q.delete();
    endtask

    // tag text: mostly valid numbers, plus overflow, blanks, signs and junk
    task automatic add_random_tag();
        int sel;
        logic [7:0] junk;
        sel = $urandom_range(99);
        junk = 8'($urandom_range(8'h5A, 8'h41));
        if (sel < 40)
            add_text($sformatf("%0d", $urandom_range(999)));
        else if (sel < 60)
            add_text($sformatf("%0d", $urandom_range(1048575)));
        else if (sel < 65)
            add_text("1048575");
        else if (sel < 70)
            add_text($sformatf("00%0d", $urandom_range(99999)));
        else if (sel < 76)
            add_text($sformatf("%0d", $urandom_range(9999999, 1048576)));
        else if (sel < 80)
            add_text("10485750");
        else if (sel < 85)
        begin
            case ($urandom_range(2))
                0: add_text(" ");
                1: add_text("+");
                default: add_text("-");
            endcase
            add_text($sformatf("%0d", $urandom_range(9999)));
        end
        else if (sel < 90)
            add_text($sformatf("%0d%c%0d", $urandom_range(999), junk, $urandom_range(99)));
        else if (sel < 96)
            add_text($sformatf("%c", junk));
        // otherwise empty tag
    endtask

    // well-formed message with random tags and value bytes
    task automatic add_random_message();
        int tokens;
        int vlen;
        logic [7:0] b;
        tokens = $urandom_range(5, 1);
        for (int t = 0; t < tokens; t++)
        begin
            if (t != 0)
                msg_q.push_back(tvfp_pkg::SEP_BYTE);
            add_random_tag();
            if ($urandom_range(99) < 90)
            begin
                msg_q.push_back(tvfp_pkg::EQ_BYTE);
                vlen = $urandom_range(6, 0);
                for (int i = 0; i < vlen; i++)
                begin
                    b = 8'($urandom_range(255));
                    if (b == tvfp_pkg::SEP_BYTE)
                        b = tvfp_pkg::EQ_BYTE;
                    msg_q.push_back(b);
                end
            end
        end
        if ($urandom_range(3) == 0)
            msg_q.push_back(tvfp_pkg::SEP_BYTE);
        emit_message();
    endtask

    // raw bytes with random end marks
    task automatic add_noise();
        stream_byte_t item;
        int n;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++)
        begin
            item.data = 8'($urandom_range(255));
            item.last = ($urandom_range(4) == 0);
            pending_q.push_back(item);
        end
    endtask

    task automatic fill_random(input int count);
        int target;
        target = pending_q.size() + count;
        while (pending_q.size() < target)
        begin
            if ($urandom_range(9) == 0)
                add_noise();
            else
                add_random_message();
        end
    endtask

    task automatic wait_sent();
        while (pending_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: max tag, 0xff and '=' in a value, last byte a plain value byte
        add_text("1048575=");
        msg_q.push_back(8'hFF);
        msg_q.push_back(tvfp_pkg::EQ_BYTE);
        emit_message();
        // empty token, empty tag dropped, zero value byte, last byte a separator
        add_text("|=a|2=");
        msg_q.push_back(8'h00);
        msg_q.push_back(tvfp_pkg::SEP_BYTE);
        emit_message();
        // sign in front of the digits, last byte the '='
        add_text("+1=");
        emit_message();
        // digits stopped by a letter
        add_text("5a9=z");
        emit_message();
        // last byte in tag phase
        add_text("7");
        emit_message();
        // valid tag closed by a last '='
        add_text("0=");
        emit_message();
        // last byte inside a dropped token
        add_text("x=q");
        emit_message();

        // no idling
        fill_random(290);
        wait_sent();

        // sender idle
        send_idle_pct = 48;
        recv_stall_pct = 0;
        fill_random(310);
        wait_sent();

        // receiver stalling
        send_idle_pct = 0;
        recv_stall_pct = 48;
        fill_random(310);
        wait_sent();

        // both
        send_idle_pct = 18;
        recv_stall_pct = 18;
        fill_random(310);
        wait_sent();

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
